### rtl/core/sacf_pkg.sv
// Package for the set-associative FIFO cache model.
// Holds the controller state type and the configuration register indexes.
// No dependencies.
package sacf_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam int CFG_DATA_W = 4;
    localparam int OUT_COUNT_W = 32;

endpackage

### rtl/core/set_assoc_cache_fifo_unit.sv
// Top level of the set-associative cache model with FIFO replacement.
// Depends on sacf_pkg (state type, register indexes) and sacf_ram (row storage).

// Each input word is one access (a byte address and a write flag); each output
// word reports hit, memory read, memory write and the four saturating totals.
// An access is accepted in ST_IDLE, where the set's row is read from the tag
// RAM and the valid/FIFO RAM; in ST_LOOKUP the row is compared across the ways
// in use, the victim is chosen and, on a miss, the row is written back once the
// output register is free. A new access is not taken until the previous one has
// left ST_LOOKUP, but may be accepted while the previous result still waits on
// the output. After reset the block runs a clearing pass over all 2^MAX_SET_BITS
// sets (1024 by default) that zeroes the valid bits and FIFO pointers; s_ready
// stays low during it, while configuration writes are taken as always.
// Configuration must only be written while no access is in flight.
module set_assoc_cache_fifo_unit #(
    parameter int MAX_SET_BITS = 10,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 48,
    parameter int COUNT_BITS   = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_we,
    input  logic [sacf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sacf_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [ADDR_BITS-1:0]                  s_address,
    input  logic                                  s_is_write,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit,
    output logic                                  m_memory_read,
    output logic                                  m_memory_write,
    output logic [sacf_pkg::OUT_COUNT_W-1:0]      m_hit_count,
    output logic [sacf_pkg::OUT_COUNT_W-1:0]      m_miss_count,
    output logic [sacf_pkg::OUT_COUNT_W-1:0]      m_read_count,
    output logic [sacf_pkg::OUT_COUNT_W-1:0]      m_write_count
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int META_W   = MAX_WAYS + WAY_W;
    localparam int TROW_W   = MAX_WAYS * ADDR_BITS;
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

    // Configuration registers.
    logic [3:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [3:0] ways_in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= 4'd5;
            index_bits_reg  <= 4'd0;
            ways_in_use_reg <= 4'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sacf_pkg::CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                sacf_pkg::CFG_INDEX_BITS:  index_bits_reg  <= cfg_data;
                sacf_pkg::CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective index width and way count after clamping.
    logic [4:0]        ib_eff;
    logic [5:0]        ways_req;
    logic [WCNT_W-1:0] ways_eff;

    always_comb begin
        if ({1'b0, index_bits_reg} > 5'(MAX_SET_BITS)) begin
            ib_eff = 5'(MAX_SET_BITS);
        end else begin
            ib_eff = {1'b0, index_bits_reg};
        end
        ways_req = {2'b00, ways_in_use_reg};
        if (ways_req == 6'd0) begin
            ways_eff = WCNT_W'(1);
        end else if (ways_req > 6'(MAX_WAYS)) begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end else begin
            ways_eff = WCNT_W'(ways_req);
        end
    end

    // Address split at acceptance: set index and tag of the incoming word.
    logic [ADDR_BITS-1:0] set_shifted;
    logic [SET_W-1:0]     set_mask;
    logic [SET_W-1:0]     in_set;
    logic [5:0]           tag_shift;
    logic [ADDR_BITS-1:0] in_tag;

    always_comb begin
        set_shifted = s_address >> offset_bits_reg;
        for (int i = 0; i < SET_W; i++) begin
            set_mask[i] = (5'(i) < ib_eff);
        end
        in_set    = set_shifted[SET_W-1:0] & set_mask;
        tag_shift = 6'(offset_bits_reg) + 6'(ib_eff);
        // A shift that reaches the address width leaves a zero tag.
        in_tag    = s_address >> tag_shift;
    end

    // Controller.
    sacf_pkg::state_t state_reg, state_next;
    logic [SET_W-1:0] clr_addr_reg;
    logic             accept;
    logic             out_free;
    logic             fire;
    logic             clearing;
    logic             m_valid_reg;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sacf_pkg::ST_CLEAR: begin
                if (clr_addr_reg == LAST_SET) begin
                    state_next = sacf_pkg::ST_IDLE;
                end
            end
            sacf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sacf_pkg::ST_LOOKUP;
                end
            end
            sacf_pkg::ST_LOOKUP: begin
                if (out_free) begin
                    state_next = sacf_pkg::ST_IDLE;
                end
            end
            default: state_next = sacf_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        fire     = 1'b0;
        clearing = 1'b0;
        unique case (state_reg)
            sacf_pkg::ST_CLEAR:  clearing = 1'b1;
            sacf_pkg::ST_IDLE:   s_ready  = 1'b1;
            sacf_pkg::ST_LOOKUP: fire     = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sacf_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (clearing) begin
                clr_addr_reg <= clr_addr_reg + SET_W'(1);
            end
        end
    end

    // Access held for the lookup state.
    logic [SET_W-1:0]     set_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic                 is_write_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            set_reg      <= in_set;
            tag_reg      <= in_tag;
            is_write_reg <= s_is_write;
        end
    end

    // Row storage: one tag row and one valid/FIFO row per set.
    logic [TROW_W-1:0] tag_row;
    logic [TROW_W-1:0] tag_row_next;
    logic [META_W-1:0] meta_row;
    logic [META_W-1:0] meta_row_next;
    logic              meta_we;
    logic [SET_W-1:0]  meta_waddr;
    logic [META_W-1:0] meta_wdata;
    logic              miss_fire;

    sacf_ram #(
        .WIDTH (TROW_W),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (miss_fire),
        .wr_addr (set_reg),
        .wr_data (tag_row_next),
        .rd_en   (accept),
        .rd_addr (in_set),
        .rd_data (tag_row)
    );

    sacf_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_SETS)
    ) u_meta_ram (
        .aclk    (aclk),
        .wr_en   (meta_we),
        .wr_addr (meta_waddr),
        .wr_data (meta_wdata),
        .rd_en   (accept),
        .rd_addr (in_set),
        .rd_data (meta_row)
    );

    // During the clearing pass every row gets zero valid bits and a zero
    // FIFO pointer; afterwards the row is only written on a miss.
    assign meta_we    = clearing || miss_fire;
    assign meta_waddr = clearing ? clr_addr_reg : set_reg;
    assign meta_wdata = clearing ? '0 : meta_row_next;

    // Lookup: parallel tag compare over the ways in use, lowest free way,
    // and the FIFO victim when the set is full.
    logic [MAX_WAYS-1:0] row_valid;
    logic [WAY_W-1:0]    row_oldest;
    logic                hit;
    logic                free_found;
    logic [WAY_W-1:0]    free_way;
    logic [WAY_W-1:0]    fifo_way;
    logic [WAY_W-1:0]    victim;
    logic [WCNT_W-1:0]   victim_inc;
    logic [WAY_W-1:0]    oldest_next;
    logic                in_use;

    always_comb begin
        row_valid  = meta_row[MAX_WAYS-1:0];
        row_oldest = meta_row[META_W-1:MAX_WAYS];
        hit        = 1'b0;
        free_found = 1'b0;
        free_way   = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use = (WCNT_W'(w) < ways_eff);
            if (in_use && row_valid[w]) begin
                if (tag_row[w*ADDR_BITS +: ADDR_BITS] == tag_reg) begin
                    hit = 1'b1;
                end
            end else if (in_use && !free_found) begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
        end

        // A pointer left beyond the ways in use restarts at way 0.
        if (WCNT_W'(row_oldest) >= ways_eff) begin
            fifo_way = '0;
        end else begin
            fifo_way = row_oldest;
        end
        victim     = free_found ? free_way : fifo_way;
        victim_inc = WCNT_W'(victim) + WCNT_W'(1);
        if (victim_inc == ways_eff) begin
            oldest_next = '0;
        end else begin
            oldest_next = WAY_W'(victim_inc);
        end

        tag_row_next = tag_row;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_W'(w) == victim) begin
                tag_row_next[w*ADDR_BITS +: ADDR_BITS] = tag_reg;
            end
        end

        meta_row_next[MAX_WAYS-1:0] = row_valid | (MAX_WAYS'(1) << victim);
        meta_row_next[META_W-1:MAX_WAYS] = free_found ? row_oldest : oldest_next;
    end

    assign miss_fire = fire && !hit;

    // Saturating totals. They only move when a result is loaded into the
    // output register, which happens only once the previous result is taken,
    // so the output fields can show them directly.
    logic [COUNT_BITS-1:0] hit_total_reg;
    logic [COUNT_BITS-1:0] miss_total_reg;
    logic [COUNT_BITS-1:0] read_total_reg;
    logic [COUNT_BITS-1:0] write_total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            read_total_reg  <= '0;
            write_total_reg <= '0;
        end else if (fire) begin
            if (hit) begin
                if (hit_total_reg != '1) begin
                    hit_total_reg <= hit_total_reg + COUNT_BITS'(1);
                end
            end else begin
                if (miss_total_reg != '1) begin
                    miss_total_reg <= miss_total_reg + COUNT_BITS'(1);
                end
                if (read_total_reg != '1) begin
                    read_total_reg <= read_total_reg + COUNT_BITS'(1);
                end
            end
            if (is_write_reg && (write_total_reg != '1)) begin
                write_total_reg <= write_total_reg + COUNT_BITS'(1);
            end
        end
    end

    // Output register.
    logic m_hit_reg;
    logic m_memory_write_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_hit_reg          <= hit;
            m_memory_write_reg <= is_write_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_memory_read  = !m_hit_reg;
    assign m_memory_write = m_memory_write_reg;
    assign m_hit_count    = sacf_pkg::OUT_COUNT_W'(hit_total_reg);
    assign m_miss_count   = sacf_pkg::OUT_COUNT_W'(miss_total_reg);
    assign m_read_count   = sacf_pkg::OUT_COUNT_W'(read_total_reg);
    assign m_write_count  = sacf_pkg::OUT_COUNT_W'(write_total_reg);

endmodule

### rtl/core/sacf_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the tag rows and the valid/FIFO rows of the cache. No dependencies.
module sacf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### tb/sv/set_assoc_cache_fifo_unit_check.sv
`timescale 1ns / 1ps
// Scoreboard for set_assoc_cache_fifo_unit: mirrors the cache lines, FIFO heads and totals,
// predicts each result word from the accepted access words and compares them field by field.
// Depends on sacf_pkg for the register indexes and the port widths.
module set_assoc_cache_fifo_unit_check #(
    parameter int MAX_SET_BITS = 10,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 48
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [sacf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sacf_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic [ADDR_BITS-1:0]                  s_address,
    input  logic                                  s_is_write,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic                                  m_hit,
    input  logic                                  m_memory_read,
    input  logic                                  m_memory_write,
    input  logic [sacf_pkg::OUT_COUNT_W-1:0]      m_hit_count,
    input  logic [sacf_pkg::OUT_COUNT_W-1:0]      m_miss_count,
    input  logic [sacf_pkg::OUT_COUNT_W-1:0]      m_read_count,
    input  logic [sacf_pkg::OUT_COUNT_W-1:0]      m_write_count,
    output int                                    mismatch_count,
    output int                                    words_in_flight,
    output int                                    words_checked,
    output int                                    hits_seen
);
    import sacf_pkg::*;

    localparam int NUM_SETS    = 1 << MAX_SET_BITS;
    localparam int NUM_LINES   = NUM_SETS * MAX_WAYS;
    localparam int MAX_PRINTED = 40;
    localparam logic [OUT_COUNT_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic                   hit;
        logic                   memory_read;
        logic                   memory_write;
        logic [OUT_COUNT_W-1:0] hit_count;
        logic [OUT_COUNT_W-1:0] miss_count;
        logic [OUT_COUNT_W-1:0] read_count;
        logic [OUT_COUNT_W-1:0] write_count;
    } access_outcome_t;

    // Mirror of the cache contents and the geometry currently programmed.
    logic [ADDR_BITS-1:0]   tag_store [NUM_LINES];
    bit                     line_live [NUM_LINES];
    int                     fifo_head [NUM_SETS];
    logic [CFG_DATA_W-1:0]  blk_shift;
    logic [CFG_DATA_W-1:0]  set_bits;
    logic [CFG_DATA_W-1:0]  way_count;
    logic [OUT_COUNT_W-1:0] hits_acc, misses_acc, fills_acc, stores_acc;
    access_outcome_t        outcome_q [$];

    function automatic logic [OUT_COUNT_W-1:0] bump(input logic [OUT_COUNT_W-1:0] v);
        return (v == TOTAL_MAX) ? v : v + OUT_COUNT_W'(1);
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_COUNT_W-1:0] got,
                                   input logic [OUT_COUNT_W-1:0] want);
        if (mismatch_count < MAX_PRINTED) begin
            $display("[%0t] mismatch, %s: got %0h, expected %0h (result word %0d)",
                     $time, what, got, want, words_checked);
        end
        mismatch_count++;
    endtask

    task automatic compare_field(input string what, input logic [OUT_COUNT_W-1:0] got,
                                 input logic [OUT_COUNT_W-1:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Looks the address up in the mirror, allocates on a miss and returns the word
    // that the block should produce for this access.
    task automatic lookup_and_fill(input logic [ADDR_BITS-1:0] addr, input logic wr,
                                   output access_outcome_t res);
        int                   sbits, nways, tag_shift, set_no, base, victim, free_way;
        logic [ADDR_BITS-1:0] set_mask, tag;
        bit                   found;
        // Oversized set counts clamp to the largest the block has, and a way count of
        // zero or beyond the physical ways clamps into the legal range.
        sbits = (int'(set_bits) > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits);
        nways = int'(way_count);
        if (nways == 0) nways = 1;
        if (nways > MAX_WAYS) nways = MAX_WAYS;
        set_mask  = '1;
        set_mask  = ~(set_mask << sbits);
        set_no    = int'((addr >> blk_shift) & set_mask);
        tag_shift = int'(blk_shift) + sbits;
        tag       = (tag_shift < ADDR_BITS) ? (addr >> tag_shift) : '0;
        base      = set_no * MAX_WAYS;
        found     = 1'b0;
        free_way  = -1;
        for (int w = 0; w < nways; w++) begin
            if (line_live[base + w]) begin
                if (tag_store[base + w] == tag) found = 1'b1;
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        if (found) begin
            hits_acc = bump(hits_acc);
        end else begin
            misses_acc = bump(misses_acc);
            fills_acc  = bump(fills_acc);
            if (free_way >= 0) begin
                victim = free_way;
            end else begin
                // A head left beyond the ways in use by a narrower geometry restarts at way 0.
                victim = fifo_head[set_no];
                if (victim >= nways) victim = 0;
                fifo_head[set_no] = (victim + 1) % nways;
            end
            line_live[base + victim] = 1'b1;
            tag_store[base + victim] = tag;
        end
        if (wr) stores_acc = bump(stores_acc);
        res = {found, ~found, wr, hits_acc, misses_acc, fills_acc, stores_acc};
    endtask

    always @(posedge aclk) begin
        access_outcome_t got, want;
        if (!aresetn) begin
            blk_shift      = 4'd5;
            set_bits       = 4'd0;
            way_count      = 4'd1;
            hits_acc       = '0;
            misses_acc     = '0;
            fills_acc      = '0;
            stores_acc     = '0;
            mismatch_count = 0;
            words_checked  = 0;
            hits_seen      = 0;
            for (int i = 0; i < NUM_LINES; i++) begin
                line_live[i] = 1'b0;
                tag_store[i] = '0;
            end
            for (int i = 0; i < NUM_SETS; i++) fifo_head[i] = 0;
            outcome_q.delete();
        end else begin
            // Results are retired before new accesses are queued, so a stray result word
            // can never be matched against an access taken on the same edge.
            if (m_valid && m_ready) begin
                got = {m_hit, m_memory_read, m_memory_write,
                       m_hit_count, m_miss_count, m_read_count, m_write_count};
                if (outcome_q.size() == 0) begin
                    report_mismatch("result word with no access outstanding", '0, '0);
                end else begin
                    want = outcome_q.pop_front();
                    compare_field("hit", OUT_COUNT_W'(got.hit), OUT_COUNT_W'(want.hit));
                    compare_field("memory_read", OUT_COUNT_W'(got.memory_read),
                                  OUT_COUNT_W'(want.memory_read));
                    compare_field("memory_write", OUT_COUNT_W'(got.memory_write),
                                  OUT_COUNT_W'(want.memory_write));
                    compare_field("hit_count", got.hit_count, want.hit_count);
                    compare_field("miss_count", got.miss_count, want.miss_count);
                    compare_field("read_count", got.read_count, want.read_count);
                    compare_field("write_count", got.write_count, want.write_count);
                end
                if (got.hit) hits_seen++;
                words_checked++;
            end
            if (s_valid && s_ready) begin
                lookup_and_fill(s_address, s_is_write, want);
                outcome_q.push_back(want);
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_OFFSET_BITS: blk_shift = cfg_data;
                    CFG_INDEX_BITS:  set_bits  = cfg_data;
                    CFG_WAYS_IN_USE: way_count = cfg_data;
                    default: ;
                endcase
            end
        end
        words_in_flight <= outcome_q.size();
    end

endmodule

### tb/sv/set_assoc_cache_fifo_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for set_assoc_cache_fifo_unit: makes reset, geometry writes and access words,
// and prints the verdict. Depends on sacf_pkg, the block and set_assoc_cache_fifo_unit_check.
module set_assoc_cache_fifo_unit_test;
    import sacf_pkg::*;

    localparam int ADDR_W          = 48;
    localparam int MAX_SET_BITS    = 10;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 206;
    localparam int POOL_DEPTH      = 16;
    localparam int SETTLE_CYCLES   = 8;

    logic                   aclk       = 1'b0;
    logic                   aresetn    = 1'b0;
    logic                   cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index  = CFG_OFFSET_BITS;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   s_valid    = 1'b0;
    logic                   s_ready;
    logic [ADDR_W-1:0]      s_address  = '0;
    logic                   s_is_write = 1'b0;
    logic                   m_valid;
    logic                   m_ready    = 1'b0;
    logic                   m_hit;
    logic                   m_memory_read;
    logic                   m_memory_write;
    logic [OUT_COUNT_W-1:0] m_hit_count;
    logic [OUT_COUNT_W-1:0] m_miss_count;
    logic [OUT_COUNT_W-1:0] m_read_count;
    logic [OUT_COUNT_W-1:0] m_write_count;

    // Idle percentages for the sender and the receiver; zero means never idle.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int cycle_count        = 0;
    int geometries         = 1;
    int accesses_sent      = 0;
    int mismatch_count, words_in_flight, words_checked, hits_seen;

    // Geometry as last programmed, used only to shape addresses so that they land on
    // a handful of tags per set and actually collide.
    logic [CFG_DATA_W-1:0]  cur_shift    = 4'd5;
    logic [CFG_DATA_W-1:0]  cur_set_bits = 4'd0;
    logic [ADDR_W-1:0]      recent_addr [POOL_DEPTH];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    set_assoc_cache_fifo_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_address      (s_address),
        .s_is_write     (s_is_write),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_memory_read  (m_memory_read),
        .m_memory_write (m_memory_write),
        .m_hit_count    (m_hit_count),
        .m_miss_count   (m_miss_count),
        .m_read_count   (m_read_count),
        .m_write_count  (m_write_count)
    );

    set_assoc_cache_fifo_unit_check scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_address       (s_address),
        .s_is_write      (s_is_write),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_memory_read   (m_memory_read),
        .m_memory_write  (m_memory_write),
        .m_hit_count     (m_hit_count),
        .m_miss_count    (m_miss_count),
        .m_read_count    (m_read_count),
        .m_write_count   (m_write_count),
        .mismatch_count  (mismatch_count),
        .words_in_flight (words_in_flight),
        .words_checked   (words_checked),
        .hits_seen       (hits_seen)
    );

    // The receiver decides afresh on every edge whether it takes the result word.
    always @(posedge aclk) begin
        m_ready <= (int'($urandom_range(99)) >= receiver_stall_pct);
    end

    // Watchdog. The limit is many times the slowest legal run, including the clearing
    // pass after reset.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Writes the three geometry registers on back-to-back edges, then drops the
    // write enable. Only called while no access is in flight.
    task automatic program_geometry(input logic [CFG_DATA_W-1:0] shift,
                                    input logic [CFG_DATA_W-1:0] set_sel,
                                    input logic [CFG_DATA_W-1:0] ways);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OFFSET_BITS;
        cfg_data  <= shift;
        @(posedge aclk);
        cfg_index <= CFG_INDEX_BITS;
        cfg_data  <= set_sel;
        @(posedge aclk);
        cfg_index <= CFG_WAYS_IN_USE;
        cfg_data  <= ways;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        cur_shift    = shift;
        cur_set_bits = (set_sel > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : set_sel;
        geometries++;
    endtask

    // Presents one access word and returns at the edge that accepts it. The valid
    // stays high on return so that the next word can follow without a gap.
    task automatic issue_access(input logic [ADDR_W-1:0] addr, input logic wr);
        if (sender_idle_pct > 0 && int'($urandom_range(99)) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do begin
                @(posedge aclk);
            end while (int'($urandom_range(99)) < sender_idle_pct);
        end
        s_valid    <= 1'b1;
        s_address  <= addr;
        s_is_write <= wr;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        accesses_sent++;
    endtask

    // Stops sending and waits until the scoreboard holds no outstanding word. The
    // count it reads is registered and lags the scoreboard, so the wait is on the safe side.
    task automatic drain_results();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (words_in_flight != 0);
    endtask

    // Half the addresses come back from a pool of recent ones (mostly hits), about a
    // third are compact addresses with only a few tags per set (fills and evictions),
    // and the rest are full-width random words.
    function automatic logic [ADDR_W-1:0] pick_address();
        int                roll;
        logic [ADDR_W-1:0] span_mask;
        roll      = $urandom_range(99);
        span_mask = '1;
        span_mask = ~(span_mask << (int'(cur_shift) + int'(cur_set_bits) + 4));
        if (roll < 50) begin
            return recent_addr[$urandom_range(POOL_DEPTH - 1)] ^ ADDR_W'($urandom_range(3));
        end else if (roll < 85) begin
            return {16'h0, $urandom} & span_mask;
        end
        return {16'($urandom), $urandom};
    endfunction

    initial begin
        logic [ADDR_W-1:0] addr;
        for (int i = 0; i < POOL_DEPTH; i++) recent_addr[i] = {16'($urandom), $urandom};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset geometry: a single line for the whole address
        // space, so a second block always evicts the first. Includes both address extremes.
        issue_access(48'h0, 1'b0);
        issue_access(48'h0, 1'b1);
        issue_access(48'h1F, 1'b0);
        issue_access(48'h20, 1'b0);
        issue_access(48'h0, 1'b0);
        issue_access(48'hFFFF_FFFF_FFFF, 1'b1);
        issue_access(48'hFFFF_FFFF_FFFF, 1'b0);
        drain_results();

        // Four ways in four sets: fill set 0, then three evictions in FIFO order and a
        // write hit on the line that survived.
        program_geometry(4'd4, 4'd2, 4'd4);
        issue_access(48'h000, 1'b0);
        issue_access(48'h040, 1'b1);
        issue_access(48'h080, 1'b0);
        issue_access(48'h0C0, 1'b0);
        issue_access(48'h100, 1'b0);
        issue_access(48'h000, 1'b1);
        issue_access(48'h040, 1'b0);
        issue_access(48'h0C4, 1'b1);
        drain_results();

        // Narrowing to two ways leaves the FIFO head of set 0 beyond the ways in use,
        // so the next eviction has to restart at way 0.
        program_geometry(4'd4, 4'd2, 4'd2);
        issue_access(48'h200, 1'b0);
        issue_access(48'h000, 1'b0);
        drain_results();

        // Oversized block shift and set count, and a way count of zero.
        program_geometry(4'd15, 4'd15, 4'd0);
        issue_access(48'h0, 1'b0);
        issue_access(48'h8000, 1'b1);
        issue_access(48'hFFFF_FFFF_FFFF, 1'b0);
        drain_results();

        // Way count above the physical ways, with byte-sized blocks.
        program_geometry(4'd0, 4'd0, 4'd15);
        issue_access(48'h1, 1'b0);
        issue_access(48'h2, 1'b1);

        // Random part: one geometry per phase, the idling pattern rotating through
        // none, sender only, receiver only and both.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: program_geometry(4'd0, 4'd0, 4'd1);
                1: program_geometry(4'd12, 4'd10, 4'd8);
                2: program_geometry(4'd2, 4'd3, 4'd4);
                3: program_geometry(4'd0, 4'd0, 4'd8);
                4: program_geometry(4'd6, 4'd10, 4'd1);
                5: program_geometry(4'(13 + $urandom_range(2)), 4'(11 + $urandom_range(4)),
                                    ($urandom_range(1) != 0) ? 4'd0 : 4'(9 + $urandom_range(6)));
                6: program_geometry(4'd3, 4'd1, 4'd3);
                default: program_geometry(4'($urandom_range(12)), 4'($urandom_range(10)),
                                          4'($urandom_range(1, 8)));
            endcase
            case (phase % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 69;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 69;
                end
                default: begin
                    sender_idle_pct    = 34;
                    receiver_stall_pct = 34;
                end
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                addr = pick_address();
                issue_access(addr, 1'($urandom));
                recent_addr[$urandom_range(POOL_DEPTH - 1)] = addr;
                // Halfway through, the sender holds off until the pipeline is empty.
                if (n == WORDS_PER_PHASE / 2) drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d access words over %0d cache geometries with four idling patterns.",
                 accesses_sent, geometries);
        $display("Compared %0d result words, %0d of them hits; %0d field mismatches.",
                 words_checked, hits_seen, mismatch_count);
        if (mismatch_count == 0 && words_in_flight == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
